### design/rme_pkg.sv
// Package for the RSA modular exponentiation engine.
// It holds the field widths, the configuration register indexes and their reset values.
// It depends on nothing else.
package rme_pkg;

    // Widths of the fixed ports.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int VALUE_W     = 32;
    localparam int RESULT_W    = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODULUS     = 2'd0,
        CFG_PUBLIC_EXP  = 2'd1,
        CFG_PRIVATE_EXP = 2'd2
    } cfg_index_t;

    // Kind codes of an input word.
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    // Reset values of the configuration registers, wide enough for any datapath width up to 64 bits.
    localparam logic [63:0] RST_MODULUS     = 64'd3233;
    localparam logic [63:0] RST_PUBLIC_EXP  = 64'd17;
    localparam logic [63:0] RST_PRIVATE_EXP = 64'd2753;

endpackage

### design/rsa_modexp_engine.sv
// Top level of the RSA modular exponentiation engine: result = value^exponent mod modulus.
// It holds the configuration registers, the sequencer and the bit-serial modular multiplier.
// It depends on rme_pkg.
//
//   Channel  | Signals                       | Direction | Word
//   ---------+-------------------------------+-----------+------------------------------
//   input    | in_valid, in_stall            | in / out  | kind, value
//   output   | out_valid, out_stall          | out / in  | result
//   config   | cfg_we, cfg_index, cfg_data   | in        | modulus, public/private exp
//
// One word first has its base reduced, then is squared for every exponent bit and
// multiplied for every exponent bit that is set, through the one-bit-per-cycle
// multiplier; a zero modulus skips this work and gives zero.
// One word is in work at a time; in_stall is high from acceptance until the result
// has moved into the output register, which holds it while out_stall is high.
// Reset loads the configuration registers with their defaults and empties the output.
module rsa_modexp_engine #(
    parameter int WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [rme_pkg::VALUE_W-1:0]       value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rme_pkg::RESULT_W-1:0]      result,
    input  logic                              cfg_we,
    input  logic [rme_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rme_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0]    CNT_MAX = CW'(WIDTH - 1);
    localparam logic [WIDTH-1:0] ONE     = {{(WIDTH-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQR,
        S_MUL,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] pub_reg;
    logic [WIDTH-1:0] priv_reg;

    // Sequencer and datapath registers.
    state_t           state_reg,  state_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    logic [CW-1:0]    ecnt_reg,   ecnt_next;
    logic [WIDTH-1:0] exp_reg,    exp_next;
    logic [WIDTH-1:0] val_reg,    val_next;
    logic [WIDTH-1:0] rem_reg,    rem_next;
    logic [WIDTH-1:0] base_reg,   base_next;
    logic [WIDTH-1:0] a_reg,      a_next;
    logic [WIDTH-1:0] mb_reg,     mb_next;
    logic [WIDTH-1:0] prod_reg,   prod_next;
    logic [WIDTH-1:0] acc_reg,    acc_next;
    logic [rme_pkg::RESULT_W-1:0] result_reg, result_next;
    logic             ovalid_reg, ovalid_next;

    // Combinational datapath values.
    logic [WIDTH:0]   mod_ext;
    logic [WIDTH:0]   red_sh;
    logic [WIDTH-1:0] red_step;
    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] mul_step;
    logic [WIDTH-1:0] acc_init;
    logic             out_free;
    logic             adv;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= rme_pkg::RST_MODULUS[WIDTH-1:0];
            pub_reg  <= rme_pkg::RST_PUBLIC_EXP[WIDTH-1:0];
            priv_reg <= rme_pkg::RST_PRIVATE_EXP[WIDTH-1:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rme_pkg::CFG_MODULUS:     mod_reg  <= WIDTH'(cfg_data);
                rme_pkg::CFG_PUBLIC_EXP:  pub_reg  <= WIDTH'(cfg_data);
                rme_pkg::CFG_PRIVATE_EXP: priv_reg <= WIDTH'(cfg_data);
                default:                  ;
            endcase
        end
    end

    // One restoring step of the base reduction: shift in the next value bit, subtract once.
    assign mod_ext  = {1'b0, mod_reg};
    assign red_sh   = {rem_reg, val_reg[WIDTH-1]};
    assign red_step = (red_sh >= mod_ext) ? WIDTH'(red_sh - mod_ext) : WIDTH'(red_sh);

    // One step of the shift-and-add multiplier: double mod m, then add the multiplicand
    // mod m when the current multiplier bit is set. Both operands stay below m.
    assign dbl      = {prod_reg, 1'b0};
    assign dbl_red  = (dbl >= mod_ext) ? WIDTH'(dbl - mod_ext) : WIDTH'(dbl);
    assign sum      = {1'b0, dbl_red} + (mb_reg[WIDTH-1] ? {1'b0, a_reg} : '0);
    assign mul_step = (sum >= mod_ext) ? WIDTH'(sum - mod_ext) : WIDTH'(sum);

    // The running power starts at 1 mod m.
    assign acc_init = (mod_reg == ONE) ? '0 : ONE;

    assign out_free = !ovalid_reg || !out_stall;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ecnt_next   = ecnt_reg;
        exp_next    = exp_reg;
        val_next    = val_reg;
        rem_next    = rem_reg;
        base_next   = base_reg;
        a_next      = a_reg;
        mb_next     = mb_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        ovalid_next = ovalid_reg;
        adv         = 1'b0;

        // The held result leaves when the consumer takes it.
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    exp_next = (kind == rme_pkg::KIND_DECRYPT) ? priv_reg : pub_reg;
                    if (mod_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        val_next   = WIDTH'(value);
                        cnt_next   = CNT_MAX;
                        ecnt_next  = CNT_MAX;
                        state_next = S_REDUCE;
                    end
                end
            end

            S_REDUCE:
            begin
                rem_next = red_step;
                val_next = val_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    base_next  = red_step;
                    a_next     = acc_init;
                    mb_next    = acc_init;
                    prod_next  = '0;
                    cnt_next   = CNT_MAX;
                    state_next = S_SQR;
                end
            end

            S_SQR:
            begin
                prod_next = mul_step;
                mb_next   = mb_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (exp_reg[WIDTH-1])
                    begin
                        a_next     = mul_step;
                        mb_next    = base_reg;
                        prod_next  = '0;
                        cnt_next   = CNT_MAX;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end

            S_MUL:
            begin
                prod_next = mul_step;
                mb_next   = mb_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    adv = 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    result_next = rme_pkg::RESULT_W'(acc_reg);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Move on to the next exponent bit, or finish after the last one.
        if (adv)
        begin
            acc_next = mul_step;
            exp_next = exp_reg << 1;
            if (ecnt_reg == '0)
            begin
                state_next = S_DONE;
            end
            else
            begin
                ecnt_next  = ecnt_reg - 1'b1;
                a_next     = mul_step;
                mb_next    = mul_step;
                prod_next  = '0;
                cnt_next   = CNT_MAX;
                state_next = S_SQR;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        ecnt_reg   <= ecnt_next;
        exp_reg    <= exp_next;
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        a_reg      <= a_next;
        mb_reg     <= mb_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign result    = result_reg;

endmodule

### design/rme_checker.sv
// Port-level checker for the RSA modular exponentiation engine, and its bind statement.
// It sees only the top level's ports; it depends on rme_pkg for the port widths.
module rme_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [rme_pkg::RESULT_W-1:0]      result
);

    // A stalled output word stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result))
        else $error("output word changed while stalled");

    // Once a word is accepted the engine is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("engine took no notice of an accepted word");

    // No result can appear in the cycle right after a word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early after acceptance");

endmodule

bind rsa_modexp_engine rme_checker u_rme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
);

### tb/rsa_modexp_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rsa_modexp_engine: a directed table, then random key phases.
// Expected residues come from a square-and-multiply predictor kept inside this file.
// It depends on rme_pkg and rsa_modexp_engine.
module rsa_modexp_engine_tb;

    localparam int WIDTH = 32;
    // Slowest word: base reduction, a square per exponent bit, a multiply per set bit.
    localparam int MAX_LATENCY = 2 * WIDTH * WIDTH + WIDTH + 3;
    localparam int DRAIN_CYCLES = MAX_LATENCY + 100;
    localparam int KEY_PHASES = 10;
    localparam int WORDS_PER_PHASE = 25;
    // The sender and the receiver stop idling for this window of words.
    localparam int CALM_FIRST = 150;
    localparam int CALM_LAST = 200;
    // Long receiver hold-off that backs the engine up into its input.
    localparam int HOLD_AFTER_WORDS = 60;
    localparam int HOLD_CYCLES = 3 * MAX_LATENCY;
    // About 271 words at worst latency with stalls finish well inside this timeout,
    // which leaves a wide margin.
    localparam longint TIMEOUT_NS = 64'd40_000_000;

    // Register index that maps to no register; a write to it must be dropped.
    localparam logic [rme_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_op_t;

    typedef struct packed {
        row_op_t                          op;
        logic [rme_pkg::CFG_INDEX_W-1:0]  reg_index;
        logic [rme_pkg::CFG_DATA_W-1:0]   data;
        logic                             kind;
        logic                             literal;
        logic [rme_pkg::RESULT_W-1:0]     expected;
    } step_t;

    localparam int NUM_STEPS = 29;

    // Directed rows; a word row with literal set carries its expected residue.
    localparam step_t DIRECTED_STEPS [0:NUM_STEPS-1] = '{
        // Reset key: the textbook pair 65 -> 2790 -> 65.
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd65,       rme_pkg::KIND_ENCRYPT, 1'b1, 32'd2790},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd2790,     rme_pkg::KIND_DECRYPT, 1'b1, 32'd65},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd0,        rme_pkg::KIND_ENCRYPT, 1'b1, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'hFFFFFFFF, rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        // Base equal to and just above the modulus.
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd3233,     rme_pkg::KIND_DECRYPT, 1'b1, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd3234,     rme_pkg::KIND_ENCRYPT, 1'b1, 32'd1},
        // Zero public exponent.
        '{ROW_CFG,  rme_pkg::CFG_PUBLIC_EXP,  32'd0,        rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd12345,    rme_pkg::KIND_ENCRYPT, 1'b1, 32'd1},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'hFFFFFFFF, rme_pkg::KIND_DECRYPT, 1'b0, 32'd0},
        // Largest public exponent, zero private exponent.
        '{ROW_CFG,  rme_pkg::CFG_PUBLIC_EXP,  32'hFFFFFFFF, rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_CFG,  rme_pkg::CFG_PRIVATE_EXP, 32'd0,        rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'hFFFFFFFF, rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd0,        rme_pkg::KIND_DECRYPT, 1'b1, 32'd1},
        // Largest modulus.
        '{ROW_CFG,  rme_pkg::CFG_MODULUS,     32'hFFFFFFFF, rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'hFFFFFFFE, rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'hFFFFFFFF, rme_pkg::KIND_ENCRYPT, 1'b1, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'h80000000, rme_pkg::KIND_DECRYPT, 1'b1, 32'd1},
        // Modulus one: everything collapses to zero.
        '{ROW_CFG,  rme_pkg::CFG_MODULUS,     32'd1,        rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd7,        rme_pkg::KIND_ENCRYPT, 1'b1, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd9,        rme_pkg::KIND_DECRYPT, 1'b1, 32'd0},
        // Modulus zero gives zero.
        '{ROW_CFG,  rme_pkg::CFG_MODULUS,     32'd0,        rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd5,        rme_pkg::KIND_ENCRYPT, 1'b1, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'hFFFFFFFF, rme_pkg::KIND_DECRYPT, 1'b1, 32'd0},
        // Smallest legal modulus.
        '{ROW_CFG,  rme_pkg::CFG_MODULUS,     32'd2,        rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd3,        rme_pkg::KIND_ENCRYPT, 1'b1, 32'd1},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd2,        rme_pkg::KIND_ENCRYPT, 1'b1, 32'd0},
        // A write to the unused index must leave the modulus at two.
        '{ROW_CFG,  CFG_UNUSED,               32'h12345678, rme_pkg::KIND_ENCRYPT, 1'b0, 32'd0},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd5,        rme_pkg::KIND_ENCRYPT, 1'b1, 32'd1},
        '{ROW_WORD, rme_pkg::CFG_MODULUS,     32'd4,        rme_pkg::KIND_DECRYPT, 1'b1, 32'd1}
    };

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             kind = rme_pkg::KIND_ENCRYPT;
    logic [rme_pkg::VALUE_W-1:0]      value = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [rme_pkg::RESULT_W-1:0]     result;
    logic                             cfg_we = 1'b0;
    logic [rme_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [rme_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    // Shadow copy of the key registers.
    logic [rme_pkg::CFG_DATA_W-1:0]   key_modulus = rme_pkg::RST_MODULUS[rme_pkg::CFG_DATA_W-1:0];
    logic [rme_pkg::CFG_DATA_W-1:0]   key_public =
        rme_pkg::RST_PUBLIC_EXP[rme_pkg::CFG_DATA_W-1:0];
    logic [rme_pkg::CFG_DATA_W-1:0]   key_private =
        rme_pkg::RST_PRIVATE_EXP[rme_pkg::CFG_DATA_W-1:0];

    logic [rme_pkg::RESULT_W-1:0]     expected_residues [$];
    int                               words_sent = 0;
    int                               results_seen = 0;
    int                               key_writes = 0;
    int                               error_count = 0;

    rsa_modexp_engine #(
        .WIDTH(WIDTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Square-and-multiply over all exponent bits; products fit in 64 bits.
    function automatic logic [rme_pkg::RESULT_W-1:0] mod_power(
        input logic [rme_pkg::VALUE_W-1:0]    base,
        input logic [rme_pkg::CFG_DATA_W-1:0] expo,
        input logic [rme_pkg::CFG_DATA_W-1:0] modulus
    );
        logic [63:0] acc;
        logic [63:0] reduced;
        if (modulus == '0)
        begin
            return '0;
        end
        acc = 64'd1 % modulus;
        reduced = base % modulus;
        for (int i = rme_pkg::CFG_DATA_W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % modulus;
            if (expo[i])
            begin
                acc = (acc * reduced) % modulus;
            end
        end
        return acc[rme_pkg::RESULT_W-1:0];
    endfunction

    // Exponent mix: zero, all ones, short, or full width.
    function automatic logic [rme_pkg::CFG_DATA_W-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(1, 65535);
            default: return $urandom();
        endcase
    endfunction

    // Offer one word and hold it until accepted; then record its residue.
    task automatic offer_word(
        input logic                         kind_in,
        input logic [rme_pkg::VALUE_W-1:0]  value_in,
        input logic                         literal,
        input logic [rme_pkg::RESULT_W-1:0] literal_residue
    );
        logic [rme_pkg::CFG_DATA_W-1:0] expo;
        logic [rme_pkg::RESULT_W-1:0]   residue;
        while (!(words_sent >= CALM_FIRST && words_sent < CALM_LAST)
               && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= kind_in;
        value <= value_in;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expo = (kind_in == rme_pkg::KIND_DECRYPT) ? key_private : key_public;
        if (literal)
        begin
            residue = literal_residue;
        end
        else
        begin
            residue = mod_power(value_in, expo, key_modulus);
        end
        expected_residues.insert(expected_residues.size(), residue);
        words_sent++;
    endtask

    // Stop offering and wait until every outstanding word has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_residues.size() != 0);
    endtask

    // One register write, after which the write enable drops again before the task returns.
    task automatic write_register(
        input logic [rme_pkg::CFG_INDEX_W-1:0] index,
        input logic [rme_pkg::CFG_DATA_W-1:0]  data
    );
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            rme_pkg::CFG_MODULUS:     key_modulus = data;
            rme_pkg::CFG_PUBLIC_EXP:  key_public = data;
            rme_pkg::CFG_PRIVATE_EXP: key_private = data;
            default:                  ;
        endcase
        key_writes++;
        @(posedge clk);
    endtask

    // Receiver: check each accepted result word and drive the stall pattern.
    initial
    begin : receiver
        logic [rme_pkg::RESULT_W-1:0] want;
        int                           hold_left;
        bit                           hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_residues.size() == 0)
                begin
                    $error("result word %h arrived with nothing outstanding", result);
                    error_count++;
                end
                else
                begin
                    want = expected_residues.pop_front();
                    if (result !== want)
                    begin
                        $error("field result: expected %h, actual %h", want, result);
                        error_count++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && words_sent >= HOLD_AFTER_WORDS)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 37);
            end
        end
    end

    // Sender: reset, directed table, then random key phases.
    initial
    begin : stimulus
        logic [rme_pkg::VALUE_W-1:0]    word_value;
        logic [rme_pkg::CFG_DATA_W-1:0] new_modulus;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_STEPS; i++)
        begin
            if (DIRECTED_STEPS[i].op == ROW_CFG)
            begin
                wait_idle();
                write_register(DIRECTED_STEPS[i].reg_index, DIRECTED_STEPS[i].data);
            end
            else
            begin
                offer_word(DIRECTED_STEPS[i].kind, DIRECTED_STEPS[i].data,
                           DIRECTED_STEPS[i].literal, DIRECTED_STEPS[i].expected);
            end
        end

        // Each phase loads a fresh key, then streams random words under it.
        for (int phase = 0; phase < KEY_PHASES; phase++)
        begin
            wait_idle();
            case ($urandom_range(0, 11))
                0: new_modulus = 32'd2;
                1: new_modulus = '1;
                2: new_modulus = $urandom_range(2, 255);
                3: new_modulus = $urandom_range(0, 1);
                default: new_modulus = $urandom();
            endcase
            write_register(rme_pkg::CFG_MODULUS, new_modulus);
            write_register(rme_pkg::CFG_PUBLIC_EXP, pick_exponent());
            write_register(rme_pkg::CFG_PRIVATE_EXP, pick_exponent());
            repeat (WORDS_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0: word_value = '0;
                    1: word_value = '1;
                    2: word_value = key_modulus;
                    3: word_value = (key_modulus != '0) ? $urandom() % key_modulus
                                                        : $urandom();
                    default: word_value = $urandom();
                endcase
                offer_word(1'($urandom_range(0, 1)), word_value, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d words through %0d register writes, %0d results checked",
                 words_sent, key_writes, results_seen);
        $display("summary: key extremes, zero and unit moduli, and a long output hold-off");
        if (error_count == 0)
        begin
            $display("rsa_modexp_engine_tb: done, clean");
        end
        else
        begin
            $display("rsa_modexp_engine_tb: done, errors");
        end
        $finish;
    end

    // Hard stop if the engine hangs.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("rsa_modexp_engine_tb: done, errors");
        $finish;
    end

endmodule
